/* hw/rtl/krc_pkg.sv */
// ----------------------------------------------------------------------------
// krc_pkg: shared types and constants for the Krylov rank core
// Holds the modular arithmetic constants and the controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package krc_pkg;

    localparam int EW = 31;
    localparam int NPRIMES = 3;
    localparam int PW = 2;

    typedef logic [EW-1:0] elem_t;
    typedef logic [5:0] fold_t;

    localparam elem_t PRIME [NPRIMES] = '{31'd2147483647, 31'd2147483629, 31'd2147483587};
    localparam fold_t PRIME_D [NPRIMES] = '{6'd1, 6'd19, 6'd61};

    localparam logic [3:0] ALPH_RESET [4] = '{4'd0, 4'd1, 4'd2, 4'd3};

    typedef struct packed {
        logic          capture;
        logic          kstep;
        logic          clear_basis;
        logic          load_row;
        logic          store;
        logic          mul;
        logic          red1;
        logic          red2;
        logic          sub;
        logic          snap_t;
        logic          take_best;
        logic [1:0]    col;
        logic [PW-1:0] prime;
    } krc_cmd_t;

    typedef struct packed {
        logic v_nz;
        logic slot_valid;
    } krc_status_t;

endpackage

/* hw/rtl/krylov_rank_4d_core.sv */
// ----------------------------------------------------------------------------
// krylov_rank_4d_core: exact Krylov subspace ranks of a 4x4 integer matrix
// Top level with the alphabet configuration registers, controller and
// datapath.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low. The core then runs
// KRYLOV_STEPS matrix-vector products, and for each of three primes clears
// the basis in a setup state, inserts its KRYLOV_STEPS+3 rows and closes by
// collecting the best ranks. A row is loaded, tested column by column and
// closed in an end state; each elimination on the shared four-lane modular
// multiplier runs the multiply, first reduction, second reduction and subtract
// states, after which the column is tested again. result_valid is high for
// exactly one cycle with the ranks and T2; the receiver cannot stall it, and
// busy drops in the following cycle.
module krylov_rank_4d_core #(
    parameter int KRYLOV_STEPS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  m_row0,
    input  logic [7:0]  m_row1,
    input  logic [7:0]  m_row2,
    input  logic [7:0]  m_row3,
    input  logic [3:0]  t_0,
    input  logic [3:0]  t_1,
    input  logic [3:0]  t_2,
    input  logic [3:0]  t_3,
    output logic        result_valid,
    output logic [2:0]  krylov_alph_dim,
    output logic [2:0]  krylov_t_rank,
    output logic [7:0]  t2_0,
    output logic [7:0]  t2_1,
    output logic [7:0]  t2_2,
    output logic [7:0]  t2_3
);
    import krc_pkg::*;

    localparam int RW  = $clog2(KRYLOV_STEPS + 3);
    localparam int KIW = (KRYLOV_STEPS > 1) ? $clog2(KRYLOV_STEPS) : 1;

    logic [3:0]     alph_reg [4];
    krc_cmd_t       cmd;
    krc_status_t    status;
    logic [RW-1:0]  row_idx;
    logic [KIW-1:0] step_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                alph_reg[i] <= ALPH_RESET[i];
            end
        end
        else if (psel && penable && pwrite)
        begin
            alph_reg[paddr[3:2]] <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {28'd0, alph_reg[paddr[3:2]]};

    krc_ctrl #(
        .KRYLOV_STEPS(KRYLOV_STEPS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .status       (status),
        .cmd          (cmd),
        .row_idx      (row_idx),
        .step_idx     (step_idx),
        .busy         (busy),
        .result_valid (result_valid)
    );

    krc_dp #(
        .KRYLOV_STEPS(KRYLOV_STEPS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .row_idx         (row_idx),
        .step_idx        (step_idx),
        .m_row0          (m_row0),
        .m_row1          (m_row1),
        .m_row2          (m_row2),
        .m_row3          (m_row3),
        .t_0             (t_0),
        .t_1             (t_1),
        .t_2             (t_2),
        .t_3             (t_3),
        .alph_0          (alph_reg[0]),
        .alph_1          (alph_reg[1]),
        .alph_2          (alph_reg[2]),
        .alph_3          (alph_reg[3]),
        .status          (status),
        .krylov_alph_dim (krylov_alph_dim),
        .krylov_t_rank   (krylov_t_rank),
        .t2_0            (t2_0),
        .t2_1            (t2_1),
        .t2_2            (t2_2),
        .t2_3            (t2_3)
    );

    a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (krylov_t_rank <= krylov_alph_dim))
        else $error("Rank without the alphabet exceeds rank with it.");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (krylov_alph_dim <= 3'd4 && krylov_t_rank != 3'd0))
        else $error("Rank outside the possible range.");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !result_valid))
        else $error("Accepted transaction did not make the core busy.");

endmodule

/* hw/rtl/krc_dp.sv */
// ----------------------------------------------------------------------------
// krc_dp: Krylov rank datapath
// Builds the Krylov vectors and inserts each row into an echelon basis with
// one pivot slot per column, using modular row updates on four lanes.
// ----------------------------------------------------------------------------
module krc_dp #(
    parameter int KRYLOV_STEPS = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  krc_pkg::krc_cmd_t                     cmd,
    input  logic [$clog2(KRYLOV_STEPS+3)-1:0]     row_idx,
    input  logic [((KRYLOV_STEPS>1)?$clog2(KRYLOV_STEPS):1)-1:0] step_idx,
    input  logic [7:0]                            m_row0,
    input  logic [7:0]                            m_row1,
    input  logic [7:0]                            m_row2,
    input  logic [7:0]                            m_row3,
    input  logic [3:0]                            t_0,
    input  logic [3:0]                            t_1,
    input  logic [3:0]                            t_2,
    input  logic [3:0]                            t_3,
    input  logic [3:0]                            alph_0,
    input  logic [3:0]                            alph_1,
    input  logic [3:0]                            alph_2,
    input  logic [3:0]                            alph_3,
    output krc_pkg::krc_status_t                  status,
    output logic [2:0]                            krylov_alph_dim,
    output logic [2:0]                            krylov_t_rank,
    output logic [7:0]                            t2_0,
    output logic [7:0]                            t2_1,
    output logic [7:0]                            t2_2,
    output logic [7:0]                            t2_3
);
    import krc_pkg::*;

    localparam int VW  = 4 + 4 * KRYLOV_STEPS;
    localparam int RW  = $clog2(KRYLOV_STEPS + 3);
    localparam int KIW = (KRYLOV_STEPS > 1) ? $clog2(KRYLOV_STEPS) : 1;

    logic [1:0]    mat_reg   [4][4];
    logic [3:0]    t_reg     [4];
    logic [VW-1:0] kcur_reg  [4];
    logic [VW-1:0] kv_reg    [KRYLOV_STEPS][4];
    elem_t         v_reg     [4];
    elem_t         basis_reg [4][4];
    logic [3:0]    bvalid_reg;
    logic [2:0]    rank_reg;
    logic [2:0]    rank_t_reg;
    logic [2:0]    best_t_reg;
    logic [2:0]    best_a_reg;
    logic [61:0]   px_reg    [4];
    logic [61:0]   py_reg    [4];
    logic [37:0]   fx_reg    [4];
    logic [37:0]   fy_reg    [4];
    elem_t         rx_reg    [4];
    elem_t         ry_reg    [4];

    logic [VW-1:0] knext [4];
    elem_t         src   [4];
    logic [RW-1:0] row_m2;
    elem_t         p_sel;
    fold_t         d_sel;
    logic [37:0]   fx_n  [4];
    logic [37:0]   fy_n  [4];
    elem_t         rx_n  [4];
    elem_t         ry_n  [4];
    elem_t         dif_n [4];
    logic [7:0]    mrow  [4];

    assign mrow[0] = m_row0;
    assign mrow[1] = m_row1;
    assign mrow[2] = m_row2;
    assign mrow[3] = m_row3;
    assign p_sel   = PRIME[cmd.prime];
    assign d_sel   = PRIME_D[cmd.prime];
    assign row_m2  = row_idx - RW'(2);

    always_comb
    begin
        logic [VW+3:0] s;
        for (int c = 0; c < 4; c++)
        begin
            s = '0;
            for (int r = 0; r < 4; r++)
            begin
                s = s + (VW+4)'(mat_reg[r][c]) * (VW+4)'(kcur_reg[r]);
            end
            knext[c] = s[VW-1:0];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            src[c] = EW'(kv_reg[row_m2[KIW-1:0]][c]);
        end
        if (row_idx == RW'(0))
        begin
            for (int c = 0; c < 4; c++)
            begin
                src[c] = EW'(1);
            end
        end
        else if (row_idx == RW'(1))
        begin
            for (int c = 0; c < 4; c++)
            begin
                src[c] = EW'(t_reg[c]);
            end
        end
        else if (row_idx == RW'(KRYLOV_STEPS + 2))
        begin
            src[0] = EW'(alph_0);
            src[1] = EW'(alph_1);
            src[2] = EW'(alph_2);
            src[3] = EW'(alph_3);
        end
    end

    always_comb
    begin
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] dd;
        for (int j = 0; j < 4; j++)
        begin
            fx_n[j] = 38'(px_reg[j][61:31]) * 38'(d_sel) + 38'(px_reg[j][30:0]);
            fy_n[j] = 38'(py_reg[j][61:31]) * 38'(d_sel) + 38'(py_reg[j][30:0]);
            wx = 32'(fx_reg[j][37:31]) * 32'(d_sel) + 32'(fx_reg[j][30:0]);
            wy = 32'(fy_reg[j][37:31]) * 32'(d_sel) + 32'(fy_reg[j][30:0]);
            rx_n[j] = (wx >= 32'(p_sel)) ? EW'(wx - 32'(p_sel)) : EW'(wx);
            ry_n[j] = (wy >= 32'(p_sel)) ? EW'(wy - 32'(p_sel)) : EW'(wy);
            dd = 32'(rx_reg[j]) - 32'(ry_reg[j]);
            if (rx_reg[j] < ry_reg[j])
            begin
                dd = dd + 32'(p_sel);
            end
            dif_n[j] = dd[EW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    mat_reg[r][c] <= mrow[r][2*c +: 2];
                end
            end
            t_reg[0]    <= t_0;
            t_reg[1]    <= t_1;
            t_reg[2]    <= t_2;
            t_reg[3]    <= t_3;
            kcur_reg[0] <= VW'(t_0);
            kcur_reg[1] <= VW'(t_1);
            kcur_reg[2] <= VW'(t_2);
            kcur_reg[3] <= VW'(t_3);
        end
        if (cmd.kstep)
        begin
            for (int c = 0; c < 4; c++)
            begin
                kcur_reg[c]           <= knext[c];
                kv_reg[step_idx][c]   <= knext[c];
            end
        end
        if (cmd.load_row)
        begin
            for (int c = 0; c < 4; c++)
            begin
                v_reg[c] <= src[c];
            end
        end
        if (cmd.store)
        begin
            for (int c = 0; c < 4; c++)
            begin
                basis_reg[cmd.col][c] <= v_reg[c];
            end
        end
        if (cmd.mul)
        begin
            for (int j = 0; j < 4; j++)
            begin
                px_reg[j] <= 62'(v_reg[j]) * 62'(basis_reg[cmd.col][cmd.col]);
                py_reg[j] <= 62'(basis_reg[cmd.col][j]) * 62'(v_reg[cmd.col]);
            end
        end
        if (cmd.red1)
        begin
            for (int j = 0; j < 4; j++)
            begin
                fx_reg[j] <= fx_n[j];
                fy_reg[j] <= fy_n[j];
            end
        end
        if (cmd.red2)
        begin
            for (int j = 0; j < 4; j++)
            begin
                rx_reg[j] <= rx_n[j];
                ry_reg[j] <= ry_n[j];
            end
        end
        if (cmd.sub)
        begin
            for (int j = 0; j < 4; j++)
            begin
                v_reg[j] <= dif_n[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg <= '0;
            rank_reg   <= '0;
            rank_t_reg <= '0;
            best_t_reg <= '0;
            best_a_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                best_t_reg <= '0;
                best_a_reg <= '0;
            end
            if (cmd.clear_basis)
            begin
                bvalid_reg <= '0;
                rank_reg   <= '0;
            end
            if (cmd.store)
            begin
                bvalid_reg[cmd.col] <= 1'b1;
                rank_reg            <= rank_reg + 3'd1;
            end
            if (cmd.snap_t)
            begin
                rank_t_reg <= rank_reg;
            end
            if (cmd.take_best)
            begin
                if (rank_t_reg > best_t_reg)
                begin
                    best_t_reg <= rank_t_reg;
                end
                if (rank_reg > best_a_reg)
                begin
                    best_a_reg <= rank_reg;
                end
            end
        end
    end

    assign status.v_nz       = (v_reg[cmd.col] != '0);
    assign status.slot_valid = bvalid_reg[cmd.col];

    assign krylov_alph_dim = best_a_reg;
    assign krylov_t_rank   = best_t_reg;
    assign t2_0 = kv_reg[0][0][7:0];
    assign t2_1 = kv_reg[0][1][7:0];
    assign t2_2 = kv_reg[0][2][7:0];
    assign t2_3 = kv_reg[0][3][7:0];

endmodule

/* hw/rtl/krc_ctrl.sv */
// ----------------------------------------------------------------------------
// krc_ctrl: Krylov rank controller
// Sequences the Krylov steps, then for each prime inserts every row into the
// pivot basis and collects the best ranks.
// ----------------------------------------------------------------------------
module krc_ctrl #(
    parameter int KRYLOV_STEPS = 3
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  krc_pkg::krc_status_t                  status,
    output krc_pkg::krc_cmd_t                     cmd,
    output logic [$clog2(KRYLOV_STEPS+3)-1:0]     row_idx,
    output logic [((KRYLOV_STEPS>1)?$clog2(KRYLOV_STEPS):1)-1:0] step_idx,
    output logic                                  busy,
    output logic                                  result_valid
);
    import krc_pkg::*;

    localparam int RW  = $clog2(KRYLOV_STEPS + 3);
    localparam int KIW = (KRYLOV_STEPS > 1) ? $clog2(KRYLOV_STEPS) : 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_KRY   = 4'd1;
    localparam logic [3:0] ST_PINIT = 4'd2;
    localparam logic [3:0] ST_RLOAD = 4'd3;
    localparam logic [3:0] ST_RCOL  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_RED1  = 4'd6;
    localparam logic [3:0] ST_RED2  = 4'd7;
    localparam logic [3:0] ST_SUB   = 4'd8;
    localparam logic [3:0] ST_REND  = 4'd9;
    localparam logic [3:0] ST_PEND  = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0]     state_reg, state_next;
    logic [KIW-1:0] step_reg, step_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [1:0]     col_reg, col_next;
    logic [PW-1:0]  prime_reg, prime_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        prime_next = prime_reg;
        cmd        = '0;
        cmd.col    = col_reg;
        cmd.prime  = prime_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    prime_next  = '0;
                    state_next  = ST_KRY;
                end
            end
            ST_KRY:
            begin
                cmd.kstep = 1'b1;
                step_next = step_reg + KIW'(1);
                if (step_reg == KIW'(KRYLOV_STEPS - 1))
                begin
                    state_next = ST_PINIT;
                end
            end
            ST_PINIT:
            begin
                cmd.clear_basis = 1'b1;
                row_next        = '0;
                state_next      = ST_RLOAD;
            end
            ST_RLOAD:
            begin
                cmd.load_row = 1'b1;
                col_next     = '0;
                state_next   = ST_RCOL;
            end
            ST_RCOL:
            begin
                if (!status.v_nz)
                begin
                    col_next = col_reg + 2'd1;
                    if (col_reg == 2'd3)
                    begin
                        state_next = ST_REND;
                    end
                end
                else if (!status.slot_valid)
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_REND;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_RED1;
            end
            ST_RED1:
            begin
                cmd.red1   = 1'b1;
                state_next = ST_RED2;
            end
            ST_RED2:
            begin
                cmd.red2   = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = ST_RCOL;
            end
            ST_REND:
            begin
                if (row_reg == RW'(KRYLOV_STEPS + 1))
                begin
                    cmd.snap_t = 1'b1;
                end
                if (row_reg == RW'(KRYLOV_STEPS + 2))
                begin
                    state_next = ST_PEND;
                end
                else
                begin
                    row_next   = row_reg + RW'(1);
                    state_next = ST_RLOAD;
                end
            end
            ST_PEND:
            begin
                cmd.take_best = 1'b1;
                if (prime_reg == PW'(NPRIMES - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    prime_next = prime_reg + PW'(1);
                    state_next = ST_PINIT;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            prime_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            prime_reg <= prime_next;
        end
    end

    assign row_idx      = row_reg;
    assign step_idx     = step_reg;
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_DONE);

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy)
        else $error("Controller stayed busy after the result strobe.");

    a_store_needs_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (status.v_nz && !status.slot_valid))
        else $error("Basis slot written without a free pivot.");

    a_sub_follows_red2: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sub |-> $past(cmd.red2))
        else $error("Row update written before reduction finished.");

endmodule
